/* hdl/vsa_pkg.sv */
// Package for the versioned snapshot array unit.
// Holds operation and status codes, controller states and shared constants.
// Used by vsa_ctrl and versioned_snapshot_array_unit.
package vsa_pkg;

	localparam int VALUE_W  = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	localparam int DEF_MAX_INDICES   = 256;
	localparam int DEF_MAX_SNAPSHOTS = 64;
	localparam int DEF_ERA_ID_BITS   = 16;

	typedef enum logic [OP_W-1:0] {
		OP_SET   = 2'd0,
		OP_BEGIN = 2'd1,
		OP_GET   = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_UNKNOWN_ERA = 2'd1,
		ST_BAD_INDEX   = 2'd2,
		ST_FULL        = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_WALK,
		S_WAIT
	} state_t;

	typedef struct packed {
		logic clearing;
		logic searching;
		logic walking;
		logic waiting;
	} ctrl_flags_t;

endpackage

/* hdl/vsa_ram.sv */
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the era id store and the value store; no package dependencies.
module vsa_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/vsa_ctrl.sv */
// Sequencer of the versioned snapshot array: decodes transactions, drives both RAMs,
// clears the written marks after reset and holds the result register.
// Depends on vsa_pkg.
module vsa_ctrl #(
	parameter int MAX_INDICES   = 256,
	parameter int MAX_SNAPSHOTS = 64,
	parameter int ERA_ID_BITS   = 16,
	localparam int IDX_W   = $clog2(MAX_INDICES),
	localparam int SIZE_W  = $clog2(MAX_INDICES + 1),
	localparam int SLOT_W  = $clog2(MAX_SNAPSHOTS),
	localparam int VADDR_W = SLOT_W + IDX_W
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [SIZE_W-1:0]                     array_size,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [vsa_pkg::OP_W-1:0]              op,
	input  logic [IDX_W-1:0]                      index,
	input  logic signed [vsa_pkg::VALUE_W-1:0]    value,
	input  logic [ERA_ID_BITS-1:0]                era_id,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [vsa_pkg::VALUE_W-1:0]    read_value,
	output logic [vsa_pkg::STATUS_W-1:0]          status,
	output logic                                  era_we,
	output logic [SLOT_W-1:0]                     era_waddr,
	output logic [ERA_ID_BITS-1:0]                era_wdata,
	output logic [SLOT_W-1:0]                     era_raddr,
	input  logic [ERA_ID_BITS-1:0]                era_rdata,
	output logic                                  val_we,
	output logic [VADDR_W-1:0]                    val_waddr,
	output logic [vsa_pkg::VALUE_W:0]             val_wdata,
	output logic [VADDR_W-1:0]                    val_raddr,
	input  logic [vsa_pkg::VALUE_W:0]             val_rdata,
	output vsa_pkg::ctrl_flags_t                  flags
);

	import vsa_pkg::*;

	localparam int CNT_W  = $clog2(MAX_SNAPSHOTS + 1);
	localparam int VDEPTH = MAX_SNAPSHOTS * (2 ** IDX_W);

	state_t                      state_q, state_d;
	logic [CNT_W-1:0]            closed_q;
	logic [ERA_ID_BITS-1:0]      open_era_q;
	logic [VADDR_W-1:0]          clr_q;
	logic [SLOT_W-1:0]           ptr_q, ptr_d;
	logic [IDX_W-1:0]            idx_q;
	logic [ERA_ID_BITS-1:0]      era_q;
	logic signed [VALUE_W-1:0]   pend_value_q;
	status_t                     pend_status_q;
	logic                        out_valid_q;
	logic signed [VALUE_W-1:0]   read_value_q;
	status_t                     status_q;

	logic [SIZE_W-1:0]           limit;
	logic                        idx_ok;
	logic                        full;
	logic [SLOT_W-1:0]           closed_slot;
	logic [SLOT_W-1:0]           last_slot;
	logic [SLOT_W-1:0]           ptr_dec;
	logic                        out_free;
	logic                        accept;
	logic                        finish;
	logic                        capture;
	logic                        load_out;
	logic signed [VALUE_W-1:0]   res_value;
	status_t                     res_status;

	assign limit = (array_size > SIZE_W'(MAX_INDICES)) ? SIZE_W'(MAX_INDICES) : array_size;
	assign idx_ok = SIZE_W'(index) < limit;
	assign full = closed_q == CNT_W'(MAX_SNAPSHOTS);
	assign closed_slot = closed_q[SLOT_W-1:0];
	assign last_slot = SLOT_W'(closed_q - 1'b1);
	assign ptr_dec = ptr_q - 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		era_we     = 1'b0;
		era_waddr  = closed_slot;
		era_wdata  = open_era_q;
		era_raddr  = ptr_q;
		val_we     = 1'b0;
		val_waddr  = {closed_slot, index};
		val_wdata  = {1'b1, value};
		val_raddr  = {ptr_q, idx_q};
		ptr_d      = ptr_q;
		finish     = 1'b0;
		capture    = 1'b0;
		res_value  = '0;
		res_status = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				val_we    = 1'b1;
				val_waddr = clr_q;
				val_wdata = '0;
				if (clr_q == VADDR_W'(VDEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall  = 1'b0;
				era_raddr = last_slot;
				if (accept) begin
					unique case (op_t'(op))
						OP_SET: begin
							finish = 1'b1;
							if (!idx_ok) begin
								res_status = ST_BAD_INDEX;
							end else if (full) begin
								res_status = ST_FULL;
							end else begin
								val_we = 1'b1;
							end
						end
						OP_BEGIN: begin
							finish = 1'b1;
							if (full) begin
								res_status = ST_FULL;
							end else begin
								era_we = 1'b1;
							end
						end
						OP_GET: begin
							if (!idx_ok) begin
								finish     = 1'b1;
								res_status = ST_BAD_INDEX;
							end else if (closed_q == '0) begin
								finish     = 1'b1;
								res_status = ST_UNKNOWN_ERA;
							end else begin
								capture = 1'b1;
								ptr_d   = last_slot;
								state_d = S_SEARCH;
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			S_SEARCH: begin
				if (era_rdata == era_q) begin
					state_d = S_WALK;
				end else if (ptr_q == '0) begin
					finish     = 1'b1;
					res_status = ST_UNKNOWN_ERA;
				end else begin
					ptr_d     = ptr_dec;
					era_raddr = ptr_dec;
				end
			end
			S_WALK: begin
				if (val_rdata[VALUE_W]) begin
					finish    = 1'b1;
					res_value = val_rdata[VALUE_W-1:0];
				end else if (ptr_q == '0) begin
					finish = 1'b1;
				end else begin
					ptr_d     = ptr_dec;
					val_raddr = {ptr_dec, idx_q};
				end
			end
			S_WAIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (finish) begin
			state_d = out_free ? S_IDLE : S_WAIT;
		end
	end

	assign load_out = (finish || (state_q == S_WAIT)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q    <= '0;
			open_era_q  <= '0;
			clr_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ptr_q <= ptr_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (era_we) begin
				closed_q   <= closed_q + 1'b1;
				open_era_q <= era_id;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			idx_q <= index;
			era_q <= era_id;
		end
		if (finish && !out_free) begin
			pend_value_q  <= res_value;
			pend_status_q <= res_status;
		end
		if (load_out) begin
			read_value_q <= (state_q == S_WAIT) ? pend_value_q : res_value;
			status_q     <= (state_q == S_WAIT) ? pend_status_q : res_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	assign flags.clearing  = state_q == S_CLEAR;
	assign flags.searching = state_q == S_SEARCH;
	assign flags.walking   = state_q == S_WALK;
	assign flags.waiting   = state_q == S_WAIT;

endmodule

/* hdl/versioned_snapshot_array_unit.sv */
// Top level of the versioned snapshot array unit: size register, era id RAM,
// value RAM and sequencer. Depends on vsa_pkg, vsa_ram and vsa_ctrl.
//
// After reset the unit runs a clearing pass over the value RAM, over all
// MAX_SNAPSHOTS * 2**clog2(MAX_INDICES) entries (16384 with the defaults); no transaction
// is taken on the input channel until it ends, while size writes are taken at once.
// A set, a new era, an unused op and a get that fails its index check or finds no
// closed era are finished in the idle state. Any other get searches the era id RAM
// from the newest closed era backward, one entry per cycle, and walks the value RAM
// back from the matching snapshot, one snapshot per cycle. Both walks are bound by
// the single read port of each RAM. One finished result may wait in the output
// register while the next transaction is taken.
module versioned_snapshot_array_unit #(
	parameter int MAX_INDICES   = vsa_pkg::DEF_MAX_INDICES,
	parameter int MAX_SNAPSHOTS = vsa_pkg::DEF_MAX_SNAPSHOTS,
	parameter int ERA_ID_BITS   = vsa_pkg::DEF_ERA_ID_BITS,
	localparam int IDX_W  = $clog2(MAX_INDICES),
	localparam int SIZE_W = $clog2(MAX_INDICES + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [SIZE_W-1:0]                  cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [vsa_pkg::OP_W-1:0]           op,
	input  logic [IDX_W-1:0]                   index,
	input  logic signed [vsa_pkg::VALUE_W-1:0] value,
	input  logic [ERA_ID_BITS-1:0]             era_id,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [vsa_pkg::VALUE_W-1:0] read_value,
	output logic [vsa_pkg::STATUS_W-1:0]       status
);

	import vsa_pkg::*;

	localparam int SLOT_W  = $clog2(MAX_SNAPSHOTS);
	localparam int VADDR_W = SLOT_W + IDX_W;
	localparam int VDEPTH  = MAX_SNAPSHOTS * (2 ** IDX_W);

	logic [SIZE_W-1:0]      array_size_q;
	logic                   era_we;
	logic [SLOT_W-1:0]      era_waddr;
	logic [ERA_ID_BITS-1:0] era_wdata;
	logic [SLOT_W-1:0]      era_raddr;
	logic [ERA_ID_BITS-1:0] era_rdata;
	logic                   val_we;
	logic [VADDR_W-1:0]     val_waddr;
	logic [VALUE_W:0]       val_wdata;
	logic [VADDR_W-1:0]     val_raddr;
	logic [VALUE_W:0]       val_rdata;
	ctrl_flags_t            flags;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_size_q <= SIZE_W'(MAX_INDICES);
		end else if (cfg_valid && cfg_ready) begin
			array_size_q <= cfg_data;
		end
	end

	vsa_ram #(
		.DEPTH  (MAX_SNAPSHOTS),
		.ADDR_W (SLOT_W),
		.DATA_W (ERA_ID_BITS)
	) u_era_ram (
		.clk   (clk),
		.we    (era_we),
		.waddr (era_waddr),
		.wdata (era_wdata),
		.raddr (era_raddr),
		.rdata (era_rdata)
	);

	vsa_ram #(
		.DEPTH  (VDEPTH),
		.ADDR_W (VADDR_W),
		.DATA_W (VALUE_W + 1)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	vsa_ctrl #(
		.MAX_INDICES   (MAX_INDICES),
		.MAX_SNAPSHOTS (MAX_SNAPSHOTS),
		.ERA_ID_BITS   (ERA_ID_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.array_size (array_size_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.index      (index),
		.value      (value),
		.era_id     (era_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.status     (status),
		.era_we     (era_we),
		.era_waddr  (era_waddr),
		.era_wdata  (era_wdata),
		.era_raddr  (era_raddr),
		.era_rdata  (era_rdata),
		.val_we     (val_we),
		.val_waddr  (val_waddr),
		.val_wdata  (val_wdata),
		.val_raddr  (val_raddr),
		.val_rdata  (val_rdata),
		.flags      (flags)
	);

	// No input transaction is taken while the marks are being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		flags.clearing |-> in_stall)
		else $error("input transaction taken during clearing pass");

	// A failed transaction never reports a value.
	a_error_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (read_value == '0))
		else $error("nonzero read value with error status");

	// A pending result only exists while the output register is occupied.
	a_wait_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		flags.waiting |-> out_valid)
		else $error("pending result held while output register is empty");

	// Once a transaction has been taken, the clearing pass never restarts.
	a_no_clear_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !flags.clearing)
		else $error("clearing pass seen after an accepted transaction");

endmodule
